@@ rtl/core/snt_pkg.sv @@
// Package for the sorted neighbor table: sizes, status codes, item kinds.
// No dependencies.
package snt_pkg;
  localparam int unsigned MaxEntriesDefault   = 16;
  localparam int unsigned IdWidthDefault      = 16;
  localparam int unsigned PayloadWidthDefault = 64;

  typedef enum logic [2:0] {
    KIND_UPSERT = 3'd0,
    KIND_DROP   = 3'd1,
    KIND_MARK   = 3'd2,
    KIND_APPLY  = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_MARKED   = 3'd5,
    ST_APPLIED  = 3'd6,
    ST_READ     = 3'd7
  } status_t;
endpackage

@@ rtl/core/snt_if.sv @@
// Handshake channels of the sorted neighbor table: request and result.
// No dependencies; the widths are fixed in the interfaces.
interface snt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] node_id;
  logic [63:0] payload;
  logic [31:0] version;
  logic [3:0]  read_index;
  modport source (output valid, kind, node_id, payload, version, read_index, input ready);
  modport sink   (input valid, kind, node_id, payload, version, read_index, output ready);
endinterface

interface snt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  entry_count;
  logic        entry_valid;
  logic [15:0] entry_id;
  logic [63:0] entry_payload;
  logic [31:0] entry_version;
  modport source (output valid, status, entry_count, entry_valid, entry_id, entry_payload,
                  entry_version, input ready);
  modport sink   (input valid, status, entry_count, entry_valid, entry_id, entry_payload,
                  entry_version, output ready);
endinterface

@@ rtl/core/sorted_neighbor_table.sv @@
// Sorted neighbor table: ascending-id table with upsert, drop, retain, read.
// Items are handled one at a time. A read or an unused kind goes straight to the result;
// drop, mark, full and apply walk the live entries; an insert does a search walk, then a
// shift walk, one entry per cycle through one compare/move unit. A new item is taken only
// once the last result has been taken.
// Reset (rst, synchronous): count and all marks clear; entry storage is not cleared.
module sorted_neighbor_table
  import snt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = MaxEntriesDefault,
  parameter int unsigned ID_WIDTH      = IdWidthDefault,
  parameter int unsigned PAYLOAD_WIDTH = PayloadWidthDefault
) (
  input logic clk,
  input logic rst,
  snt_req_if.sink   req,
  snt_rsp_if.source rsp
);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PACK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Storage: entries live in flops, moved one per cycle by the sequencer.
  logic [ID_WIDTH-1:0]      ids      [MAX_ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] payloads [MAX_ENTRIES];
  logic [31:0]              versions [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   marks;
  logic [CW-1:0]            count;

  state_t state;
  kind_t  kind;
  logic [ID_WIDTH-1:0]      key;
  logic [PAYLOAD_WIDTH-1:0] pay;
  logic [31:0]              ver;
  logic [CW-1:0]            ptr;   // walk position
  logic [CW-1:0]            wr;    // compaction write position

  logic [2:0]  o_status;
  logic [4:0]  o_count;
  logic        o_valid;
  logic [15:0] o_id;
  logic [63:0] o_pay;
  logic [31:0] o_ver;

  // Shared unit: equality with the key at the walk position, greater-than one below.
  logic [IW-1:0]       pidx;
  logic [IW-1:0]       pidx_m1;
  logic                hit;
  logic                gt_prev;
  assign pidx    = ptr[IW-1:0];
  assign pidx_m1 = IW'(ptr - CW'(1));
  assign hit     = (ids[pidx] == key);
  assign gt_prev = (ids[pidx_m1] > key);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_DONE);
  assign rsp.status      = o_status;
  assign rsp.entry_count = o_count;
  assign rsp.entry_valid = o_valid;
  assign rsp.entry_id    = o_id;
  assign rsp.entry_payload = o_pay;
  assign rsp.entry_version = o_ver;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      marks <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key   <= ID_WIDTH'(req.node_id);
            pay   <= PAYLOAD_WIDTH'(req.payload);
            ver   <= req.version;
            ptr   <= '0;
            wr    <= '0;
            kind  <= kind_t'(req.kind);
            // Entry fields carry data only for a read inside the live entries.
            if (req.kind == KIND_READ && 32'(req.read_index) < 32'(count)) begin
              o_valid <= 1'b1;
              o_id    <= 16'(ids[IW'(req.read_index)]);
              o_pay   <= 64'(payloads[IW'(req.read_index)]);
              o_ver   <= versions[IW'(req.read_index)];
            end else begin
              o_valid <= 1'b0;
              o_id    <= '0;
              o_pay   <= '0;
              o_ver   <= '0;
            end
            unique case (req.kind)
              KIND_UPSERT, KIND_DROP, KIND_MARK: state <= S_FIND;
              KIND_APPLY: state <= S_PACK;
              KIND_READ: begin
                o_status <= ST_READ;
                o_count  <= 5'(count);
                state <= S_DONE;
              end
              default: begin
                o_status <= ST_NOTFOUND;
                o_count  <= 5'(count);
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_FIND: begin
          // Advance until a match or the end of the live entries.
          if (ptr < count && hit) begin
            unique case (kind)
              KIND_UPSERT: begin
                payloads[pidx] <= pay;
                versions[pidx] <= ver;
                o_status <= ST_UPDATED;
                o_count  <= 5'(count);
                state    <= S_DONE;
              end
              KIND_MARK: begin
                marks[pidx] <= 1'b1;
                o_status <= ST_MARKED;
                o_count  <= 5'(count);
                state    <= S_DONE;
              end
              default: begin
                ptr   <= ptr + CW'(1);
                state <= S_SHIFT;
              end
            endcase
          end else if (ptr < count) begin
            ptr <= ptr + CW'(1);
          end else if (kind == KIND_UPSERT) begin
            if (32'(count) >= MAX_ENTRIES) begin
              o_status <= ST_FULL;
              o_count  <= 5'(count);
              state    <= S_DONE;
            end else begin
              state <= S_SHIFT;   // ptr == count: shift up from the top
            end
          end else begin
            o_status <= ST_NOTFOUND;
            o_count  <= 5'(count);
            state    <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (kind == KIND_UPSERT) begin
            // Move one larger entry up, or drop the new entry in place.
            if (ptr != '0 && gt_prev) begin
              ids[pidx]      <= ids[pidx_m1];
              payloads[pidx] <= payloads[pidx_m1];
              versions[pidx] <= versions[pidx_m1];
              marks[pidx]    <= marks[pidx_m1];
              ptr <= ptr - CW'(1);
            end else begin
              ids[pidx]      <= key;
              payloads[pidx] <= pay;
              versions[pidx] <= ver;
              marks[pidx]    <= 1'b0;
              count    <= count + CW'(1);
              o_status <= ST_INSERTED;
              o_count  <= 5'(count + CW'(1));
              state    <= S_DONE;
            end
          end else begin
            // Drop: ptr is the source, close the gap one entry a cycle.
            if (ptr < count) begin
              ids[pidx_m1]      <= ids[pidx];
              payloads[pidx_m1] <= payloads[pidx];
              versions[pidx_m1] <= versions[pidx];
              marks[pidx_m1]    <= marks[pidx];
              ptr <= ptr + CW'(1);
            end else begin
              marks[IW'(count - CW'(1))] <= 1'b0;
              count    <= count - CW'(1);
              o_status <= ST_DROPPED;
              o_count  <= 5'(count - CW'(1));
              state    <= S_DONE;
            end
          end
        end
        S_PACK: begin
          // Keep marked entries in order, then clear every mark.
          if (ptr < count) begin
            if (marks[pidx]) begin
              ids[IW'(wr)]      <= ids[pidx];
              payloads[IW'(wr)] <= payloads[pidx];
              versions[IW'(wr)] <= versions[pidx];
              wr <= wr + CW'(1);
            end
            ptr <= ptr + CW'(1);
          end else begin
            marks    <= '0;
            count    <= wr;
            o_status <= ST_APPLIED;
            o_count  <= 5'(wr);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ENTRIES) else $error("count overflow");
  // A result holds until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("result dropped");
  // Insert grows the count by one.
  a_insert: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && kind == KIND_UPSERT && !(ptr != '0 && gt_prev)
    |=> count == $past(count) + CW'(1)) else $error("insert count");
endmodule

@@ bench/sorted_neighbor_table_test.sv @@
// Self-checking bench for sorted_neighbor_table: directed table, then random traffic.
// Depends on snt_pkg, snt_req_if / snt_rsp_if and the sorted_neighbor_table RTL.
module sorted_neighbor_table_test;
  import snt_pkg::*;

  localparam int unsigned TableDepth  = MaxEntriesDefault;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 2 * TableDepth + 8;
  localparam int unsigned IdPoolSize  = 24;

  typedef struct packed {
    status_t     status;
    logic [4:0]  count;
    logic        valid;
    logic [15:0] id;
    logic [63:0] payload;
    logic [31:0] version;
  } answer_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] node_id;
    logic [63:0] payload;
    logic [31:0] version;
    logic [3:0]  read_index;
  } request_t;

  // Directed row: the request, plus a typed answer where one is obvious.
  typedef struct packed {
    request_t req;
    logic     typed;
    answer_t  answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  snt_req_if req ();
  snt_rsp_if rsp ();

  sorted_neighbor_table uut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table, kept in step with every accepted item.
  logic [15:0] shadow_ids      [TableDepth];
  logic [63:0] shadow_payloads [TableDepth];
  logic [31:0] shadow_versions [TableDepth];
  logic        shadow_marks    [TableDepth];
  int unsigned shadow_count;

  answer_t pending_answers[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  bit failed;

  // Move one entry, mark included, from one slot to another.
  function automatic void shift_entry(int unsigned dst, int unsigned src);
    shadow_ids[dst]      = shadow_ids[src];
    shadow_payloads[dst] = shadow_payloads[src];
    shadow_versions[dst] = shadow_versions[src];
    shadow_marks[dst]    = shadow_marks[src];
  endfunction

  // Apply one request to the shadow table and return the answer it earns.
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int unsigned pos;
    int unsigned keep;
    a = '0;
    a.status = ST_NOTFOUND;
    pos = shadow_count;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == r.node_id && pos == shadow_count) pos = i;
    end
    case (r.kind)
      KIND_UPSERT: begin
        if (pos < shadow_count) begin
          shadow_payloads[pos] = r.payload;
          shadow_versions[pos] = r.version;
          a.status = ST_UPDATED;
        end else if (shadow_count >= TableDepth) begin
          a.status = ST_FULL;
        end else begin
          // Open a hole at the sorted position, walking down from the tail.
          pos = shadow_count;
          while (pos > 0 && shadow_ids[pos-1] > r.node_id) begin
            shift_entry(pos, pos - 1);
            pos--;
          end
          shadow_ids[pos]      = r.node_id;
          shadow_payloads[pos] = r.payload;
          shadow_versions[pos] = r.version;
          shadow_marks[pos]    = 1'b0;
          shadow_count++;
          a.status = ST_INSERTED;
        end
      end
      KIND_DROP: begin
        if (pos < shadow_count) begin
          for (int unsigned i = pos; i + 1 < shadow_count; i++) shift_entry(i, i + 1);
          shadow_count--;
          shadow_marks[shadow_count] = 1'b0;
          a.status = ST_DROPPED;
        end
      end
      KIND_MARK: begin
        if (pos < shadow_count) begin
          shadow_marks[pos] = 1'b1;
          a.status = ST_MARKED;
        end
      end
      KIND_APPLY: begin
        // Compact marked entries toward the head, then clear every mark.
        keep = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_marks[i]) begin
            if (keep != i) shift_entry(keep, i);
            keep++;
          end
        end
        shadow_count = keep;
        for (int unsigned i = 0; i < TableDepth; i++) shadow_marks[i] = 1'b0;
        a.status = ST_APPLIED;
      end
      KIND_READ: begin
        a.status = ST_READ;
        if (r.read_index < shadow_count) begin
          a.valid   = 1'b1;
          a.id      = shadow_ids[r.read_index];
          a.payload = shadow_payloads[r.read_index];
          a.version = shadow_versions[r.read_index];
        end
      end
      default: ;  // unused kinds leave the table alone
    endcase
    a.count = shadow_count[4:0];
    return a;
  endfunction

  // Present one item, hold it until accepted, then log its answer.
  task automatic send_request(request_t r, logic typed, answer_t typed_answer);
    answer_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid      <= 1'b1;
    req.kind       <= r.kind;
    req.node_id    <= r.node_id;
    req.payload    <= r.payload;
    req.version    <= r.version;
    req.read_index <= r.read_index;
    do @(posedge clk); while (!req.ready);
    predicted = apply_request(r);
    pending_answers.push_back(typed ? typed_answer : predicted);
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    logic [15:0] id_pool;
    pick = $urandom_range(99);
    // Mostly upserts and marks so the table fills and retain rounds have members.
    if (pick < 40)      r.kind = KIND_UPSERT;
    else if (pick < 52) r.kind = KIND_DROP;
    else if (pick < 72) r.kind = KIND_MARK;
    else if (pick < 76) r.kind = KIND_APPLY;
    else if (pick < 95) r.kind = KIND_READ;
    else                r.kind = 3'($urandom_range(5, 7));
    id_pool = 16'($urandom_range(IdPoolSize - 1) * 2847);
    r.node_id    = ($urandom_range(99) < 80) ? id_pool : 16'($urandom);
    r.payload    = {$urandom, $urandom};
    r.version    = $urandom;
    r.read_index = 4'($urandom);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Receiver: stall at random, check each accepted result against the oldest answer.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: status %0d", $time, rsp.status);
        failed = 1'b1;
      end else begin
        answer_t want;
        want = pending_answers.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("entry_count", want.count, rsp.entry_count);
        check_field("entry_valid", want.valid, rsp.entry_valid);
        check_field("entry_id", want.id, rsp.entry_id);
        check_field("entry_payload", want.payload, rsp.entry_payload);
        check_field("entry_version", want.version, rsp.entry_version);
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sorted_neighbor_table verification failed");
      $finish;
    end
  end

  // Directed rows. Typed answers only where the outcome is plain.
  function automatic row_t make_row(logic [2:0] k, logic [15:0] id, logic [3:0] idx,
                                    logic typed, status_t st, logic [4:0] cnt);
    row_t w;
    w = '0;
    w.req.kind       = k;
    w.req.node_id    = id;
    w.req.payload    = {$urandom, $urandom};
    w.req.version    = $urandom;
    w.req.read_index = idx;
    w.typed          = typed;
    w.answer.status  = st;
    w.answer.count   = cnt;
    return w;
  endfunction

  initial begin
    row_t rows[$];
    row_t w;
    req.valid      <= 1'b0;
    req.kind       <= '0;
    req.node_id    <= '0;
    req.payload    <= '0;
    req.version    <= '0;
    req.read_index <= '0;
    shadow_count   = 0;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      shadow_ids[i] = '0; shadow_payloads[i] = '0; shadow_versions[i] = '0;
      shadow_marks[i] = 1'b0;
    end
    send_idle_pct  = 21;
    recv_stall_pct = 60;

    // Empty table: read, drop, mark and apply all answer plainly.
    rows.push_back(make_row(KIND_READ, 16'h0000, 4'd0, 1, ST_READ, 5'd0));
    rows.push_back(make_row(KIND_DROP, 16'h1234, 4'd0, 1, ST_NOTFOUND, 5'd0));
    rows.push_back(make_row(KIND_MARK, 16'h1234, 4'd0, 1, ST_NOTFOUND, 5'd0));
    rows.push_back(make_row(KIND_APPLY, 16'h0000, 4'd0, 1, ST_APPLIED, 5'd0));
    // Extreme ids with all-ones and all-zeros payload/version.
    w = make_row(KIND_UPSERT, 16'hFFFF, 4'd0, 1, ST_INSERTED, 5'd1);
    w.req.payload = '1; w.req.version = '1;
    rows.push_back(w);
    w = make_row(KIND_UPSERT, 16'h0000, 4'd0, 1, ST_INSERTED, 5'd2);
    w.req.payload = '0; w.req.version = '0;
    rows.push_back(w);
    rows.push_back(make_row(KIND_READ, 16'h0000, 4'd0, 0, ST_READ, 5'd2));
    rows.push_back(make_row(KIND_READ, 16'h0000, 4'd1, 0, ST_READ, 5'd2));
    // Read past the end: zeros.
    rows.push_back(make_row(KIND_READ, 16'h0000, 4'd15, 1, ST_READ, 5'd2));
    rows.push_back(make_row(KIND_UPSERT, 16'h8000, 4'd0, 1, ST_INSERTED, 5'd3));
    rows.push_back(make_row(KIND_UPSERT, 16'h0000, 4'd0, 1, ST_UPDATED, 5'd3));
    rows.push_back(make_row(3'd5, 16'h0000, 4'd0, 1, ST_NOTFOUND, 5'd3));
    rows.push_back(make_row(3'd6, 16'hFFFF, 4'd0, 1, ST_NOTFOUND, 5'd3));
    rows.push_back(make_row(3'd7, 16'h8000, 4'd0, 1, ST_NOTFOUND, 5'd3));
    // Mark survives a move caused by an insert ahead of it.
    rows.push_back(make_row(KIND_MARK, 16'hFFFF, 4'd0, 1, ST_MARKED, 5'd3));
    rows.push_back(make_row(KIND_UPSERT, 16'h4000, 4'd0, 1, ST_INSERTED, 5'd4));
    rows.push_back(make_row(KIND_MARK, 16'h0000, 4'd0, 1, ST_MARKED, 5'd4));
    rows.push_back(make_row(KIND_DROP, 16'h4000, 4'd0, 1, ST_DROPPED, 5'd3));
    rows.push_back(make_row(KIND_APPLY, 16'h0000, 4'd0, 1, ST_APPLIED, 5'd2));
    rows.push_back(make_row(KIND_READ, 16'h0000, 4'd1, 0, ST_READ, 5'd2));
    rows.push_back(make_row(KIND_DROP, 16'hFFFF, 4'd0, 1, ST_DROPPED, 5'd1));
    rows.push_back(make_row(KIND_APPLY, 16'h0000, 4'd0, 1, ST_APPLIED, 5'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].answer);

    // Random part in three idle phases; the last has no idling at all.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        send_idle_pct = 60; recv_stall_pct = 21;
      end else if (n == 2 * RandomItems / 3) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      send_request(random_request(), 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (!failed) begin
      $display("sorted_neighbor_table verification clean");
    end else begin
      $display("sorted_neighbor_table verification failed");
    end
    $finish;
  end
endmodule
